// ===== rtl/core/shc_pkg.sv =====
// ----------------------------------------------------------------------------
// shc_pkg: shared types and constants of the soft/hard clipper
// Holds the register map, the configuration bundle, the fixed field widths
// and the elaboration-time builder for the tanh table.
// ----------------------------------------------------------------------------
package shc_pkg;

	localparam int SHC_SAMPLE_BITS     = 24;
	localparam int SHC_GAIN_W          = 24;
	localparam int SHC_FRAC16_W        = 17;
	localparam int SHC_CFG_INDEX_W     = 3;
	localparam int SHC_CFG_DATA_W      = 24;
	localparam int SHC_TANH_ADDR_BITS  = 8;
	localparam int SHC_TANH_DEPTH      = 1 << SHC_TANH_ADDR_BITS;
	localparam int SHC_PIPE_STAGES     = 15;
	localparam int SHC_RND_SHIFT       = 16;

	localparam logic [SHC_FRAC16_W-1:0] SHC_UNITY16    = 17'd65536;
	localparam logic [SHC_FRAC16_W-1:0] SHC_CEIL_MIN   = 17'd3277;
	localparam logic [SHC_GAIN_W-1:0]   SHC_GAIN_RESET = 24'd65536;
	localparam logic [SHC_FRAC16_W-1:0] SHC_HALF16     = 17'd32768;
	localparam logic [63:0]             SHC_TANH_STEP  = (64'd16 << 30) / SHC_TANH_DEPTH;

	typedef enum logic [SHC_CFG_INDEX_W-1:0] {
		CFG_PRE_GAIN,
		CFG_DRIVE_GAIN,
		CFG_CEILING_LEVEL,
		CFG_SAT_BLEND,
		CFG_TRIM_GAIN,
		CFG_WET_MIX,
		CFG_POWER_ON
	} shc_cfg_idx_t;

	typedef struct packed {
		logic [SHC_GAIN_W-1:0]   pre_gain;
		logic [SHC_GAIN_W-1:0]   drive_gain;
		logic [SHC_GAIN_W-1:0]   trim_gain;
		logic [SHC_FRAC16_W-1:0] ceiling_level;
		logic [SHC_FRAC16_W-1:0] sat_blend;
		logic [SHC_FRAC16_W-1:0] wet_mix;
		logic                    power_on;
	} shc_cfg_t;

	// Unsigned long division, used only while the table is built.
	function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
		logic [63:0] q;
		logic [64:0] rem;
		q   = '0;
		rem = '0;
		for (int b = 63; b >= 0; b--) begin
			rem = {rem[63:0], num[b]};
			if (rem >= {1'b0, den}) begin
				rem  = rem - {1'b0, den};
				q[b] = 1'b1;
			end
		end
		return q;
	endfunction

	// Entry k of the tanh table on [0, 8], built from a Taylor series of e^-a.
	function automatic logic [63:0] tanh_rom_entry(input int k, input int frac_bits);
		logic [63:0] one30;
		logic [63:0] a;
		logic [63:0] term;
		logic [63:0] r;
		logic [63:0] e;
		logic [63:0] den;
		one30 = 64'd1 << 30;
		a     = SHC_TANH_STEP;
		term  = one30;
		r     = one30;
		e     = one30;
		for (int n = 1; n <= 12; n++) begin
			term = udiv64((term * a) >> 30, 64'(n));
			if ((n & 1) == 1) begin
				r = r - term;
			end else begin
				r = r + term;
			end
		end
		for (int j = 0; j < k; j++) begin
			e = (e * r + (one30 >> 1)) >> 30;
		end
		den = one30 + e;
		return udiv64(((one30 - e) << frac_bits) + (den >> 1), den);
	endfunction

endpackage

// ===== rtl/core/shc_cfg.sv =====
// ----------------------------------------------------------------------------
// shc_cfg: configuration registers
// Takes register writes, keeps the settings and presents them with the
// ceiling, blend and mix limits already applied.
// ----------------------------------------------------------------------------
module shc_cfg import shc_pkg::*; #(
	parameter int SAMPLE_BITS = SHC_SAMPLE_BITS
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  logic [SHC_CFG_INDEX_W-1:0] cfg_index,
	input  logic [SHC_CFG_DATA_W-1:0]  cfg_data,
	output shc_cfg_t                   cfg,
	output logic [SAMPLE_BITS-1:0]     ceil_q
);

	localparam int F = SAMPLE_BITS - 1;

	logic [SHC_GAIN_W-1:0]   pre_gain_q;
	logic [SHC_GAIN_W-1:0]   drive_gain_q;
	logic [SHC_GAIN_W-1:0]   trim_gain_q;
	logic [SHC_FRAC16_W-1:0] ceiling_level_q;
	logic [SHC_FRAC16_W-1:0] sat_blend_q;
	logic [SHC_FRAC16_W-1:0] wet_mix_q;
	logic                    power_on_q;
	logic [SHC_FRAC16_W-1:0] ceil_clamped;
	logic [SHC_FRAC16_W+F-1:0] ceil_shifted;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pre_gain_q      <= SHC_GAIN_RESET;
			drive_gain_q    <= SHC_GAIN_RESET;
			trim_gain_q     <= SHC_GAIN_RESET;
			ceiling_level_q <= SHC_UNITY16;
			sat_blend_q     <= SHC_HALF16;
			wet_mix_q       <= SHC_UNITY16;
			power_on_q      <= 1'b0;
		end else if (cfg_valid) begin
			unique case (shc_cfg_idx_t'(cfg_index))
				CFG_PRE_GAIN:      pre_gain_q      <= cfg_data;
				CFG_DRIVE_GAIN:    drive_gain_q    <= cfg_data;
				CFG_CEILING_LEVEL: ceiling_level_q <= cfg_data[SHC_FRAC16_W-1:0];
				CFG_SAT_BLEND:     sat_blend_q     <= cfg_data[SHC_FRAC16_W-1:0];
				CFG_TRIM_GAIN:     trim_gain_q     <= cfg_data;
				CFG_WET_MIX:       wet_mix_q       <= cfg_data[SHC_FRAC16_W-1:0];
				CFG_POWER_ON:      power_on_q      <= cfg_data[0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		if (ceiling_level_q < SHC_CEIL_MIN) begin
			ceil_clamped = SHC_CEIL_MIN;
		end else if (ceiling_level_q > SHC_UNITY16) begin
			ceil_clamped = SHC_UNITY16;
		end else begin
			ceil_clamped = ceiling_level_q;
		end
		cfg.pre_gain      = pre_gain_q;
		cfg.drive_gain    = drive_gain_q;
		cfg.trim_gain     = trim_gain_q;
		cfg.ceiling_level = ceil_clamped;
		cfg.sat_blend     = (sat_blend_q > SHC_UNITY16) ? SHC_UNITY16 : sat_blend_q;
		cfg.wet_mix       = (wet_mix_q > SHC_UNITY16) ? SHC_UNITY16 : wet_mix_q;
		cfg.power_on      = power_on_q;
	end

	assign ceil_shifted = {ceil_clamped, {F{1'b0}}};
	assign ceil_q       = ceil_shifted[F+SHC_RND_SHIFT:SHC_RND_SHIFT];

endmodule

// ===== rtl/core/shc_drive.sv =====
// ----------------------------------------------------------------------------
// shc_drive: pre and drive gain stages
// Four stages: pre gain product, rounding, drive gain product, rounding with
// saturation of the driven signal to plus or minus eight.
// ----------------------------------------------------------------------------
module shc_drive import shc_pkg::*; #(
	parameter int SAMPLE_BITS = SHC_SAMPLE_BITS
) (
	input  logic                          clk,
	input  logic [3:0]                    en,
	input  logic signed [SAMPLE_BITS-1:0] x,
	input  logic [SHC_GAIN_W-1:0]         pre_gain,
	input  logic [SHC_GAIN_W-1:0]         drive_gain,
	output logic signed [SAMPLE_BITS+3:0] v_s4,
	output logic signed [SAMPLE_BITS-1:0] x_s4
);

	localparam int SB   = SAMPLE_BITS;
	localparam int P1_W = SB + SHC_GAIN_W + 1;
	localparam int V1_W = P1_W + 1 - SHC_RND_SHIFT;
	localparam int P2_W = V1_W + SHC_GAIN_W + 1;
	localparam int R_W  = P2_W + 1 - SHC_RND_SHIFT;
	localparam int V_W  = SB + 4;
	localparam logic signed [R_W-1:0] LIM_POS = R_W'(1) << (SB + 2);
	localparam logic signed [R_W-1:0] LIM_NEG = -LIM_POS;
	localparam logic [P1_W:0] HALF1 = (P1_W+1)'(1) << (SHC_RND_SHIFT - 1);
	localparam logic [P2_W:0] HALF2 = (P2_W+1)'(1) << (SHC_RND_SHIFT - 1);

	logic signed [P1_W-1:0] p1_s1;
	logic signed [V1_W-1:0] v1_s2;
	logic signed [P2_W-1:0] p2_s3;
	logic signed [SB-1:0]   x_s1;
	logic signed [SB-1:0]   x_s2;
	logic signed [SB-1:0]   x_s3;
	logic [P1_W:0]          p1_rnd;
	logic [P2_W:0]          p2_rnd;
	logic signed [R_W-1:0]  r4;
	logic signed [R_W-1:0]  r4_clamped;

	assign p1_rnd = {p1_s1[P1_W-1], p1_s1} + HALF1;
	assign p2_rnd = {p2_s3[P2_W-1], p2_s3} + HALF2;
	assign r4     = p2_rnd[P2_W:SHC_RND_SHIFT];

	always_comb begin
		if (r4 > LIM_POS) begin
			r4_clamped = LIM_POS;
		end else if (r4 < LIM_NEG) begin
			r4_clamped = LIM_NEG;
		end else begin
			r4_clamped = r4;
		end
	end

	always_ff @(posedge clk) begin
		if (en[0]) begin
			x_s1  <= x;
			p1_s1 <= P1_W'(x) * P1_W'($signed({1'b0, pre_gain}));
		end
		if (en[1]) begin
			x_s2  <= x_s1;
			v1_s2 <= p1_rnd[P1_W:SHC_RND_SHIFT];
		end
		if (en[2]) begin
			x_s3  <= x_s2;
			p2_s3 <= P2_W'(v1_s2) * P2_W'($signed({1'b0, drive_gain}));
		end
		if (en[3]) begin
			x_s4 <= x_s3;
			v_s4 <= r4_clamped[V_W-1:0];
		end
	end

endmodule

// ===== rtl/core/shc_shape.sv =====
// ----------------------------------------------------------------------------
// shc_shape: tanh and hard clip curves
// Five stages: magnitude and table address with the hard clip, table read,
// interpolation product, signed tanh value, and the hard minus soft difference.
// ----------------------------------------------------------------------------
module shc_shape import shc_pkg::*; #(
	parameter int SAMPLE_BITS = SHC_SAMPLE_BITS
) (
	input  logic                          clk,
	input  logic [4:0]                    en,
	input  logic signed [SAMPLE_BITS+3:0] v_s4,
	input  logic signed [SAMPLE_BITS-1:0] x_s4,
	input  logic [SAMPLE_BITS-1:0]        ceil_q,
	output logic signed [SAMPLE_BITS+1:0] d_s9,
	output logic signed [SAMPLE_BITS:0]   s_s9,
	output logic signed [SAMPLE_BITS-1:0] x_s9
);

	localparam int SB     = SAMPLE_BITS;
	localparam int F      = SB - 1;
	localparam int L      = SHC_TANH_ADDR_BITS;
	localparam int V_W    = SB + 4;
	localparam int M_W    = SB + 3;
	localparam int FR_W   = F + 3;
	localparam int RW     = F + 1;
	localparam int PR_W   = RW + FR_W;
	localparam int H_W    = F + 2;
	localparam int D_W    = F + 3;

	logic [RW-1:0] rom_w [SHC_TANH_DEPTH+1];

	for (genvar k = 0; k <= SHC_TANH_DEPTH; k++) begin : g_rom
		localparam logic [RW-1:0] ROM_K = RW'(tanh_rom_entry(k, F));
		assign rom_w[k] = ROM_K;
	end

	logic                  neg5;
	logic [V_W-1:0]        m_full;
	logic [M_W-1:0]        m5;
	logic signed [V_W-1:0] cq_v;
	logic signed [V_W-1:0] h5;
	logic [L:0]            idx_hi;
	logic [RW-1:0]         lo6;
	logic [RW-1:0]         hi6;
	logic [RW-1:0]         t8;
	logic [RW-1:0]         interp8;

	logic                  neg_s5, neg_s6, neg_s7;
	logic                  sat_s5, sat_s6, sat_s7;
	logic [L-1:0]          idx_s5;
	logic [FR_W-1:0]       frac_s5, frac_s6;
	logic signed [H_W-1:0] h_s5, h_s6, h_s7, h_s8;
	logic signed [SB-1:0]  x_s5, x_s6, x_s7, x_s8;
	logic [RW-1:0]         lo_s6, lo_s7;
	logic [RW-1:0]         diff_s6;
	logic [PR_W-1:0]       prod_s7;
	logic signed [H_W-1:0] s_s8;

	assign neg5   = v_s4[V_W-1];
	assign m_full = neg5 ? V_W'(-v_s4) : v_s4;
	assign m5     = m_full[M_W-1:0];
	assign cq_v   = V_W'($signed({1'b0, ceil_q}));

	always_comb begin
		if (v_s4 > cq_v) begin
			h5 = cq_v;
		end else if (v_s4 < -cq_v) begin
			h5 = -cq_v;
		end else begin
			h5 = v_s4;
		end
	end

	assign idx_hi  = {1'b0, idx_s5} + (L+1)'(1);
	assign lo6     = rom_w[{1'b0, idx_s5}];
	assign hi6     = rom_w[idx_hi];
	assign interp8 = prod_s7[PR_W-1:FR_W];
	assign t8      = sat_s7 ? rom_w[SHC_TANH_DEPTH] : lo_s7 + interp8;

	always_ff @(posedge clk) begin
		if (en[0]) begin
			neg_s5  <= neg5;
			sat_s5  <= m5[M_W-1];
			idx_s5  <= m5[F+2:F+3-L];
			frac_s5 <= {m5[F+2-L:0], {L{1'b0}}};
			h_s5    <= h5[H_W-1:0];
			x_s5    <= x_s4;
		end
		if (en[1]) begin
			neg_s6  <= neg_s5;
			sat_s6  <= sat_s5;
			frac_s6 <= frac_s5;
			lo_s6   <= lo6;
			diff_s6 <= (hi6 > lo6) ? hi6 - lo6 : '0;
			h_s6    <= h_s5;
			x_s6    <= x_s5;
		end
		if (en[2]) begin
			neg_s7  <= neg_s6;
			sat_s7  <= sat_s6;
			lo_s7   <= lo_s6;
			prod_s7 <= PR_W'(diff_s6) * PR_W'(frac_s6);
			h_s7    <= h_s6;
			x_s7    <= x_s6;
		end
		if (en[3]) begin
			s_s8 <= neg_s7 ? -$signed({1'b0, t8}) : $signed({1'b0, t8});
			h_s8 <= h_s7;
			x_s8 <= x_s7;
		end
		if (en[4]) begin
			d_s9 <= D_W'(h_s8) - D_W'(s_s8);
			s_s9 <= s_s8;
			x_s9 <= x_s8;
		end
	end

endmodule

// ===== rtl/core/shc_post.sv =====
// ----------------------------------------------------------------------------
// shc_post: blend, trim and dry/wet mix
// Six stages: blend product, rounding with the second ceiling clip, trim
// product, rounding and dry difference, mix product, final sum with output
// saturation and the bypass select.
// ----------------------------------------------------------------------------
module shc_post import shc_pkg::*; #(
	parameter int SAMPLE_BITS = SHC_SAMPLE_BITS
) (
	input  logic                          clk,
	input  logic [5:0]                    en,
	input  logic signed [SAMPLE_BITS+1:0] d_s9,
	input  logic signed [SAMPLE_BITS:0]   s_s9,
	input  logic signed [SAMPLE_BITS-1:0] x_s9,
	input  shc_cfg_t                      cfg,
	input  logic [SAMPLE_BITS-1:0]        ceil_q,
	output logic signed [SAMPLE_BITS-1:0] out_s15
);

	localparam int SB    = SAMPLE_BITS;
	localparam int F     = SB - 1;
	localparam int D_W   = F + 3;
	localparam int S_W   = F + 2;
	localparam int PB_W  = D_W + SHC_FRAC16_W + 1;
	localparam int RB_W  = PB_W + 1 - SHC_RND_SHIFT;
	localparam int Y0_W  = RB_W + 1;
	localparam int Y_W   = F + 2;
	localparam int PW_W  = Y_W + SHC_GAIN_W + 1;
	localparam int W_W   = PW_W + 1 - SHC_RND_SHIFT;
	localparam int DM_W  = W_W + 1;
	localparam int PM_W  = DM_W + SHC_FRAC16_W + 1;
	localparam int RM_W  = PM_W + 1 - SHC_RND_SHIFT;
	localparam int O_W   = RM_W + 1;
	localparam logic [PB_W:0] HALF_B = (PB_W+1)'(1) << (SHC_RND_SHIFT - 1);
	localparam logic [PW_W:0] HALF_W = (PW_W+1)'(1) << (SHC_RND_SHIFT - 1);
	localparam logic [PM_W:0] HALF_M = (PM_W+1)'(1) << (SHC_RND_SHIFT - 1);
	localparam logic signed [O_W-1:0] SMAX = O_W'((64'd1 << F) - 64'd1);
	localparam logic signed [O_W-1:0] SMIN = -SMAX - O_W'(1);

	logic signed [PB_W-1:0] pb_s10;
	logic signed [S_W-1:0]  s_s10;
	logic signed [SB-1:0]   x_s10, x_s11, x_s12, x_s13, x_s14;
	logic signed [Y_W-1:0]  y_s11;
	logic signed [PW_W-1:0] pw_s12;
	logic signed [DM_W-1:0] dm_s13;
	logic signed [PM_W-1:0] pm_s14;

	logic [PB_W:0]          pb_rnd;
	logic signed [RB_W-1:0] rb;
	logic signed [Y0_W-1:0] y0;
	logic signed [Y0_W-1:0] cq_y;
	logic signed [Y0_W-1:0] y_cl;
	logic [PW_W:0]          pw_rnd;
	logic signed [W_W-1:0]  w13;
	logic [PM_W:0]          pm_rnd;
	logic signed [RM_W-1:0] rm;
	logic signed [O_W-1:0]  o15;
	logic signed [O_W-1:0]  o_cl;

	assign pb_rnd = {pb_s10[PB_W-1], pb_s10} + HALF_B;
	assign rb     = pb_rnd[PB_W:SHC_RND_SHIFT];
	assign y0     = Y0_W'(s_s10) + Y0_W'(rb);
	assign cq_y   = Y0_W'($signed({1'b0, ceil_q}));

	always_comb begin
		if (y0 > cq_y) begin
			y_cl = cq_y;
		end else if (y0 < -cq_y) begin
			y_cl = -cq_y;
		end else begin
			y_cl = y0;
		end
	end

	assign pw_rnd = {pw_s12[PW_W-1], pw_s12} + HALF_W;
	assign w13    = pw_rnd[PW_W:SHC_RND_SHIFT];
	assign pm_rnd = {pm_s14[PM_W-1], pm_s14} + HALF_M;
	assign rm     = pm_rnd[PM_W:SHC_RND_SHIFT];
	assign o15    = O_W'(x_s14) + O_W'(rm);

	always_comb begin
		if (o15 > SMAX) begin
			o_cl = SMAX;
		end else if (o15 < SMIN) begin
			o_cl = SMIN;
		end else begin
			o_cl = o15;
		end
	end

	always_ff @(posedge clk) begin
		if (en[0]) begin
			pb_s10 <= PB_W'(d_s9) * PB_W'($signed({1'b0, cfg.sat_blend}));
			s_s10  <= s_s9[S_W-1:0];
			x_s10  <= x_s9;
		end
		if (en[1]) begin
			y_s11 <= y_cl[Y_W-1:0];
			x_s11 <= x_s10;
		end
		if (en[2]) begin
			pw_s12 <= PW_W'(y_s11) * PW_W'($signed({1'b0, cfg.trim_gain}));
			x_s12  <= x_s11;
		end
		if (en[3]) begin
			dm_s13 <= DM_W'(w13) - DM_W'(x_s12);
			x_s13  <= x_s12;
		end
		if (en[4]) begin
			pm_s14 <= PM_W'(dm_s13) * PM_W'($signed({1'b0, cfg.wet_mix}));
			x_s14  <= x_s13;
		end
		if (en[5]) begin
			out_s15 <= cfg.power_on ? o_cl[SB-1:0] : x_s14;
		end
	end

endmodule

// ===== rtl/core/soft_hard_clipper_mix_top.sv =====
// ----------------------------------------------------------------------------
// soft_hard_clipper_mix_top: tanh soft clipper with hard clip blend and mix
// Top level: configuration port, the three datapath sections and the valid
// and stall chain of the fifteen-stage pipeline.
// ----------------------------------------------------------------------------
// The block takes one sample word per clock while in_ready is high and
// returns one result per input, in order, once the word has passed the
// fifteen register stages of the datapath, which are cut around its six
// multipliers and the tanh table read. A stalled output only
// holds the stages that carry words; empty stages keep filling, so the input
// stays ready until every stage is occupied. Register writes take effect at
// once and are meant to happen while no sample is in flight. With power off
// each sample passes through unchanged at the same latency.
module soft_hard_clipper_mix_top import shc_pkg::*; #(
	parameter int SAMPLE_BITS = SHC_SAMPLE_BITS
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic signed [SAMPLE_BITS-1:0] in_sample,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic signed [SAMPLE_BITS-1:0] out_sample,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [SHC_CFG_INDEX_W-1:0]    cfg_index,
	input  logic [SHC_CFG_DATA_W-1:0]     cfg_data
);

	localparam int N = SHC_PIPE_STAGES;

	shc_cfg_t                      cfg;
	logic [SAMPLE_BITS-1:0]        ceil_q;
	logic [N-1:0]                  vld_q;
	logic [N-1:0]                  en;
	logic signed [SAMPLE_BITS+3:0] v_s4;
	logic signed [SAMPLE_BITS-1:0] x_s4;
	logic signed [SAMPLE_BITS+1:0] d_s9;
	logic signed [SAMPLE_BITS:0]   s_s9;
	logic signed [SAMPLE_BITS-1:0] x_s9;

	always_comb begin
		en[N-1] = !vld_q[N-1] || out_ready;
		for (int k = N - 2; k >= 0; k--) begin
			en[k] = !vld_q[k] || en[k+1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (en[0]) begin
				vld_q[0] <= in_valid;
			end
			for (int k = 1; k < N; k++) begin
				if (en[k]) begin
					vld_q[k] <= vld_q[k-1];
				end
			end
		end
	end

	assign in_ready  = en[0];
	assign out_valid = vld_q[N-1];

	shc_cfg #(.SAMPLE_BITS(SAMPLE_BITS)) u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg),
		.ceil_q    (ceil_q)
	);

	shc_drive #(.SAMPLE_BITS(SAMPLE_BITS)) u_drive (
		.clk        (clk),
		.en         (en[3:0]),
		.x          (in_sample),
		.pre_gain   (cfg.pre_gain),
		.drive_gain (cfg.drive_gain),
		.v_s4       (v_s4),
		.x_s4       (x_s4)
	);

	shc_shape #(.SAMPLE_BITS(SAMPLE_BITS)) u_shape (
		.clk    (clk),
		.en     (en[8:4]),
		.v_s4   (v_s4),
		.x_s4   (x_s4),
		.ceil_q (ceil_q),
		.d_s9   (d_s9),
		.s_s9   (s_s9),
		.x_s9   (x_s9)
	);

	shc_post #(.SAMPLE_BITS(SAMPLE_BITS)) u_post (
		.clk     (clk),
		.en      (en[14:9]),
		.d_s9    (d_s9),
		.s_s9    (s_s9),
		.x_s9    (x_s9),
		.cfg     (cfg),
		.ceil_q  (ceil_q),
		.out_s15 (out_sample)
	);

endmodule

// ===== rtl/core/shc_checker.sv =====
// ----------------------------------------------------------------------------
// shc_checker: port-level checks of the clipper
// Counts words in flight and checks the stall behavior seen at the ports.
// ----------------------------------------------------------------------------
module shc_checker import shc_pkg::*; #(
	parameter int SAMPLE_BITS = SHC_SAMPLE_BITS
) (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          in_valid,
	input logic                          in_ready,
	input logic signed [SAMPLE_BITS-1:0] in_sample,
	input logic                          out_valid,
	input logic                          out_ready,
	input logic signed [SAMPLE_BITS-1:0] out_sample
);

	localparam int CNT_W = $clog2(SHC_PIPE_STAGES + 1);
	localparam logic [CNT_W-1:0] FULL = CNT_W'(SHC_PIPE_STAGES);

	logic [CNT_W-1:0] inflight_q;
	logic             in_fire;
	logic             out_fire;

	assign in_fire  = in_valid && in_ready;
	assign out_fire = out_valid && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inflight_q <= '0;
		end else if (in_fire && !out_fire) begin
			inflight_q <= inflight_q + CNT_W'(1);
		end else if (out_fire && !in_fire) begin
			inflight_q <= inflight_q - CNT_W'(1);
		end
	end

	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_ready |=> in_valid && $stable(in_sample))
		else $error("Waiting input word changed or was withdrawn.");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_sample))
		else $error("Stalled output word changed or vanished.");

	a_ready_when_drained: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("Input stalled while the output stage is empty.");

	a_no_phantom: assert property (@(posedge clk) disable iff (!arst_n)
		inflight_q == '0 |-> !out_valid)
		else $error("Output word shown with no input word in flight.");

	a_capacity: assert property (@(posedge clk) disable iff (!arst_n)
		inflight_q <= FULL && (inflight_q != FULL || !in_ready || out_ready))
		else $error("Pipeline holds more words than it has stages.");

endmodule

bind soft_hard_clipper_mix_top shc_checker #(.SAMPLE_BITS(SAMPLE_BITS)) u_shc_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (in_valid),
	.in_ready   (in_ready),
	.in_sample  (in_sample),
	.out_valid  (out_valid),
	.out_ready  (out_ready),
	.out_sample (out_sample)
);
